// ===== design/urid_pkg.sv =====
// ----------------------------------------------------------------------------
// URI percent decoder package
// Shared types, constants and character helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package urid_pkg;

  localparam int unsigned UnitW       = 16;
  localparam int unsigned MaxUnits    = 3;
  localparam int unsigned QueueDepthD = 4;

  localparam logic [UnitW-1:0] PctChar     = 16'h0025;
  localparam logic [20:0]      MaxCodePt   = 21'h10FFFF;
  localparam logic [20:0]      SurrLo      = 21'h00D800;
  localparam logic [20:0]      SurrHi      = 21'h00DFFF;
  localparam logic [20:0]      SuppBase    = 21'h010000;
  localparam logic [UnitW-1:0] HiSurrBase  = 16'hD800;
  localparam logic [UnitW-1:0] LoSurrBase  = 16'hDC00;
  localparam logic [16:0]      Min2Byte    = 17'h00080;
  localparam logic [16:0]      Min3Byte    = 17'h00800;
  localparam logic [16:0]      Min4Byte    = 17'h10000;

  // One accepted request's worth of results.
  typedef struct packed {
    logic [MaxUnits-1:0][UnitW-1:0] units;
    logic [1:0]                     cnt;
    logic                           eos;
    logic                           err;
  } cmd_t;

  // Bit 4 set means the character is not a hex digit.
  function automatic logic [4:0] hex_value(input logic [UnitW-1:0] c);
    logic [4:0] r;
    r = 5'd16;
    if (c >= 16'h0030 && c <= 16'h0039) begin
      r = 5'(c - 16'h0030);
    end else if (c >= 16'h0061 && c <= 16'h0066) begin
      r = 5'(c - 16'h0057);
    end else if (c >= 16'h0041 && c <= 16'h0046) begin
      r = 5'(c - 16'h0037);
    end
    return r;
  endfunction

  function automatic logic is_preserved(input logic [7:0] b);
    logic r;
    unique case (b) inside
      8'h23, 8'h24, 8'h26, 8'h2B, 8'h2C, 8'h2F,
      8'h3A, 8'h3B, 8'h3D, 8'h3F, 8'h40: r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== design/urid_front.sv =====
// ----------------------------------------------------------------------------
// URI decoder front end
// Accepts code units, tracks escape and UTF-8 state, and builds one result
// request per input that produces output.
// ----------------------------------------------------------------------------
`default_nettype none

module urid_front (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       cfg_wr,
  input  wire logic                       cfg_mode,
  input  wire logic                       accept,
  input  wire logic [urid_pkg::UnitW-1:0] code_unit,
  input  wire logic                       last,
  output      logic                       cmd_push,
  output      urid_pkg::cmd_t             cmd
);
  import urid_pkg::*;

  typedef enum logic [1:0] {PH_IDLE, PH_PCT, PH_HEX} phase_t;

  phase_t      phase_r, phase_nxt;
  logic [7:0]  first_r, first_nxt;
  logic [1:0]  pend_r, pend_nxt;
  logic [20:0] acc_r, acc_nxt;
  logic [16:0] min_r, min_nxt;
  logic        disc_r, disc_nxt;
  logic        mode_r;

  logic [4:0]  hv;
  logic [4:0]  hf;
  logic [7:0]  b;
  logic [20:0] cp;
  logic [20:0] v;
  logic        err;
  logic [1:0]  n;
  logic [MaxUnits-1:0][UnitW-1:0] u;

  always_comb begin
    hv = hex_value(code_unit);
    hf = hex_value({8'h00, first_r});
    b  = {hf[3:0], hv[3:0]};
    cp = {acc_r[14:0], b[5:0]};
    v  = cp - SuppBase;
    err = 1'b0;
    n   = 2'd0;
    u   = '0;
    phase_nxt = phase_r;
    first_nxt = first_r;
    pend_nxt  = pend_r;
    acc_nxt   = acc_r;
    min_nxt   = min_r;
    disc_nxt  = disc_r;
    if (disc_r) begin
      if (last) begin
        disc_nxt  = 1'b0;
        phase_nxt = PH_IDLE;
        first_nxt = '0;
        pend_nxt  = '0;
        acc_nxt   = '0;
        min_nxt   = '0;
      end
    end else begin
      unique case (phase_r)
        PH_IDLE: begin
          if (code_unit == PctChar) begin
            phase_nxt = PH_PCT;
          end else if (pend_r != 2'd0) begin
            err = 1'b1;
          end else begin
            n    = 2'd1;
            u[0] = code_unit;
          end
        end
        PH_PCT: begin
          if (hv[4]) begin
            err = 1'b1;
          end else begin
            first_nxt = code_unit[7:0];
            phase_nxt = PH_HEX;
          end
        end
        PH_HEX: begin
          if (hv[4]) begin
            err = 1'b1;
          end else begin
            phase_nxt = PH_IDLE;
            if (pend_r == 2'd0) begin
              if (!b[7]) begin
                if (!mode_r && is_preserved(b)) begin
                  n    = 2'd3;
                  u[0] = PctChar;
                  u[1] = {8'h00, first_r};
                  u[2] = code_unit;
                end else begin
                  n    = 2'd1;
                  u[0] = {8'h00, b};
                end
              end else if (b < 8'hC0 || b >= 8'hF8) begin
                err = 1'b1;
              end else if (b < 8'hE0) begin
                pend_nxt = 2'd1;
                acc_nxt  = {16'h0000, b[4:0]};
                min_nxt  = Min2Byte;
              end else if (b < 8'hF0) begin
                pend_nxt = 2'd2;
                acc_nxt  = {17'h00000, b[3:0]};
                min_nxt  = Min3Byte;
              end else begin
                pend_nxt = 2'd3;
                acc_nxt  = {18'h00000, b[2:0]};
                min_nxt  = Min4Byte;
              end
            end else if (b[7:6] != 2'b10) begin
              err = 1'b1;
            end else begin
              acc_nxt  = cp;
              pend_nxt = pend_r - 2'd1;
              if (pend_r == 2'd1) begin
                acc_nxt = '0;
                min_nxt = '0;
                if (cp < {4'h0, min_r} || cp > MaxCodePt ||
                    (cp >= SurrLo && cp <= SurrHi)) begin
                  err = 1'b1;
                end else if (cp < SuppBase) begin
                  n    = 2'd1;
                  u[0] = cp[15:0];
                end else begin
                  n    = 2'd2;
                  u[0] = HiSurrBase | {6'h00, v[19:10]};
                  u[1] = LoSurrBase | {6'h00, v[9:0]};
                end
              end
            end
          end
        end
        default: err = 1'b1;
      endcase
      if (!err && last && (phase_nxt != PH_IDLE || pend_nxt != 2'd0)) begin
        err = 1'b1;
      end
      if (err || last) begin
        phase_nxt = PH_IDLE;
        first_nxt = '0;
        pend_nxt  = '0;
        acc_nxt   = '0;
        min_nxt   = '0;
      end
      if (err) begin
        disc_nxt = !last;
        n        = 2'd1;
        u        = '0;
      end
    end
  end

  always_comb begin
    cmd.units = u;
    cmd.cnt   = n;
    cmd.eos   = err || last;
    cmd.err   = err;
    cmd_push  = accept && (n != 2'd0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      first_r <= '0;
      pend_r  <= '0;
      acc_r   <= '0;
      min_r   <= '0;
      disc_r  <= 1'b0;
      mode_r  <= 1'b0;
    end else begin
      if (accept) begin
        phase_r <= phase_nxt;
        first_r <= first_nxt;
        pend_r  <= pend_nxt;
        acc_r   <= acc_nxt;
        min_r   <= min_nxt;
        disc_r  <= disc_nxt;
      end
      if (cfg_wr) begin
        mode_r <= cfg_mode;
      end
    end
  end

`ifndef SYNTH
  a_disc_clears_escape: assert property (@(posedge clk) disable iff (!rst_n)
    disc_r |-> (phase_r == PH_IDLE && pend_r == 2'd0))
    else $error("escape state left open while discarding");
  a_no_push_discarding: assert property (@(posedge clk) disable iff (!rst_n)
    disc_r |-> !cmd_push)
    else $error("result request issued while discarding");
  a_err_single: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd_push && cmd.err) |-> (cmd.cnt == 2'd1 && cmd.eos))
    else $error("malformed error request");
`endif

endmodule

`default_nettype wire

// ===== design/urid_fifo.sv =====
// ----------------------------------------------------------------------------
// URI decoder request queue
// Small queue of result requests between the front end and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module urid_fifo #(
  parameter int unsigned DEPTH = urid_pkg::QueueDepthD
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire urid_pkg::cmd_t wdata,
  input  wire logic           pop,
  output urid_pkg::cmd_t      rdata,
  output      logic           full,
  output      logic           empty
);
  import urid_pkg::*;

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

  cmd_t            mem [DEPTH];
  logic [PtrW-1:0] wptr_r, rptr_r;
  logic [CntW-1:0] cnt_r;

  assign full  = (cnt_r == FullCnt);
  assign empty = (cnt_r == '0);
  assign rdata = mem[rptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (push) begin
        wptr_r <= (wptr_r == LastPtr) ? '0 : wptr_r + 1'b1;
      end
      if (pop) begin
        rptr_r <= (rptr_r == LastPtr) ? '0 : rptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (!full || pop))
    else $error("request queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty)
    else $error("request queue underflow");
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= FullCnt)
    else $error("request queue count out of range");
`endif

endmodule

`default_nettype wire

// ===== design/urid_back.sv =====
// ----------------------------------------------------------------------------
// URI decoder back end
// Emits the code units of the oldest queued request one result at a time.
// ----------------------------------------------------------------------------
`default_nettype none

module urid_back (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire urid_pkg::cmd_t             head,
  input  wire logic                       q_empty,
  output      logic                       q_pop,
  input  wire logic                       pop,
  output      logic                       empty,
  output      logic [urid_pkg::UnitW-1:0] unit_o,
  output      logic                       eos_o,
  output      logic                       err_o
);
  import urid_pkg::*;

  logic [1:0] idx_r, idx_nxt;
  logic       at_end;

  always_comb begin
    at_end  = (idx_r == head.cnt - 2'd1);
    empty   = q_empty;
    unit_o  = head.units[idx_r];
    eos_o   = head.eos && at_end;
    err_o   = head.err;
    q_pop   = pop && !q_empty && at_end;
    idx_nxt = idx_r;
    if (pop && !q_empty) begin
      idx_nxt = at_end ? 2'd0 : idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
    end else begin
      idx_r <= idx_nxt;
    end
  end

`ifndef SYNTH
  a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    !q_empty |-> (idx_r < head.cnt))
    else $error("unit index beyond request size");
  a_idx_zero_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_empty |-> (idx_r == 2'd0))
    else $error("unit index not cleared");
  a_head_not_blank: assert property (@(posedge clk) disable iff (!rst_n)
    !q_empty |-> (head.cnt != 2'd0))
    else $error("queued request carries no units");
`endif

endmodule

`default_nettype wire

// ===== design/uri_percent_utf8_decoder.sv =====
// A result is registered in the request queue as its code unit is accepted.
// Throughput: one code unit per cycle while the request queue has room.
// A kept reserved escape yields three results and a supplementary character two,
// delivered one per pop; the queue depth sets how far input may run ahead.
// Synchronous active-low reset clears all escape state, the queue and the mode.
// ----------------------------------------------------------------------------
// URI percent UTF-8 decoder
// Decodes percent escapes in a stream of UTF-16 code units.
// ----------------------------------------------------------------------------
`default_nettype none

module uri_percent_utf8_decoder #(
  parameter int unsigned QUEUE_DEPTH = urid_pkg::QueueDepthD
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_push,
  output      logic                       in_full,
  input  wire logic [urid_pkg::UnitW-1:0] in_code_unit,
  input  wire logic                       in_last,
  output      logic                       out_empty,
  input  wire logic                       out_pop,
  output      logic [urid_pkg::UnitW-1:0] out_unit,
  output      logic                       out_end_of_string,
  output      logic                       out_error,
  input  wire logic                       cfg_valid,
  output      logic                       cfg_ready,
  input  wire logic                       cfg_data
);
  import urid_pkg::*;

  logic accept;
  logic cmd_push;
  cmd_t cmd;
  cmd_t head;
  logic q_empty;
  logic q_pop;

  assign accept    = in_push && !in_full;
  assign cfg_ready = 1'b1;

  urid_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr    (cfg_valid && cfg_ready),
    .cfg_mode  (cfg_data),
    .accept    (accept),
    .code_unit (in_code_unit),
    .last      (in_last),
    .cmd_push  (cmd_push),
    .cmd       (cmd)
  );

  urid_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (cmd_push),
    .wdata (cmd),
    .pop   (q_pop),
    .rdata (head),
    .full  (in_full),
    .empty (q_empty)
  );

  urid_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .head    (head),
    .q_empty (q_empty),
    .q_pop   (q_pop),
    .pop     (out_pop),
    .empty   (out_empty),
    .unit_o  (out_unit),
    .eos_o   (out_end_of_string),
    .err_o   (out_error)
  );

endmodule

`default_nettype wire

// ===== verif/tb_uri_percent_utf8_decoder.sv =====
// ----------------------------------------------------------------------------
// Testbench for the URI percent UTF-8 decoder
// Drives strings of UTF-16 code units through the decoder in both modes, with
// escapes, multi-byte sequences and malformed input. A scoreboard predicts the
// decoded units and checks each popped result against them in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_uri_percent_utf8_decoder;
  import urid_pkg::*;

  localparam int unsigned CycleLimit   = 200000;
  localparam int unsigned HoldCycles   = 300;
  localparam int unsigned SettleCycles = 4;

  typedef enum logic [1:0] {
    EscNone,
    EscAfterPct,
    EscAfterDigit
  } esc_phase_t;

  typedef struct {
    logic [UnitW-1:0] unit;
    logic             eos;
    logic             err;
  } dec_unit_t;

  class decode_scoreboard_t;
    logic             mode;
    esc_phase_t       phase;
    logic [UnitW-1:0] first_digit;
    logic [1:0]       pending;
    logic [20:0]      acc;
    logic [16:0]      min_cp;
    logic             discarding;
    dec_unit_t        decoded_units[$];
    int unsigned      errors;

    function new();
      mode = 1'b0;
      discarding = 1'b0;
      errors = 0;
      clear_escape();
    endfunction

    function void clear_escape();
      phase = EscNone;
      first_digit = '0;
      pending = '0;
      acc = '0;
      min_cp = '0;
    endfunction

    function int unsigned hex_nibble(logic [UnitW-1:0] c);
      if (c >= 16'h0030 && c <= 16'h0039) return 32'(c - 16'h0030);
      if (c >= 16'h0061 && c <= 16'h0066) return c - 16'h0061 + 10;
      if (c >= 16'h0041 && c <= 16'h0046) return c - 16'h0041 + 10;
      return 16;
    endfunction

    function bit is_reserved(logic [7:0] b);
      case (b)
        8'h23, 8'h24, 8'h26, 8'h2B, 8'h2C, 8'h2F,
        8'h3A, 8'h3B, 8'h3D, 8'h3F, 8'h40: return 1'b1;
        default: return 1'b0;
      endcase
    endfunction

    function void add_unit(ref dec_unit_t q[$], input logic [UnitW-1:0] u);
      dec_unit_t d;
      d.unit = u;
      d.eos = 1'b0;
      d.err = 1'b0;
      q.push_back(d);
    endfunction

    // Returns 1 when the request is decoded, 0 when it is dropped after an error.
    function bit note_request(logic [UnitW-1:0] cu, logic lst);
      dec_unit_t   fresh[$];
      dec_unit_t   fail;
      int unsigned h;
      logic [7:0]  b;
      logic [20:0] cp;
      logic [20:0] v;
      bit          bad;
      if (discarding) begin
        if (lst) begin
          discarding = 1'b0;
          clear_escape();
        end
        return 1'b0;
      end
      bad = 1'b0;
      case (phase)
        EscNone: begin
          if (cu == PctChar) phase = EscAfterPct;
          else if (pending != 0) bad = 1'b1;
          else add_unit(fresh, cu);
        end
        EscAfterPct: begin
          if (hex_nibble(cu) > 15) begin
            bad = 1'b1;
          end else begin
            first_digit = cu;
            phase = EscAfterDigit;
          end
        end
        EscAfterDigit: begin
          h = hex_nibble(cu);
          if (h > 15) begin
            bad = 1'b1;
          end else begin
            b = 8'((hex_nibble(first_digit) << 4) | h);
            phase = EscNone;
            if (pending == 0) begin
              if (b < 8'h80) begin
                if (!mode && is_reserved(b)) begin
                  add_unit(fresh, PctChar);
                  add_unit(fresh, first_digit);
                  add_unit(fresh, cu);
                end else begin
                  add_unit(fresh, {8'h00, b});
                end
              end else if (b < 8'hC0 || b >= 8'hF8) begin
                bad = 1'b1;
              end else if (b < 8'hE0) begin
                pending = 2'd1;
                acc = {16'h0, b[4:0]};
                min_cp = Min2Byte;
              end else if (b < 8'hF0) begin
                pending = 2'd2;
                acc = {17'h0, b[3:0]};
                min_cp = Min3Byte;
              end else begin
                pending = 2'd3;
                acc = {18'h0, b[2:0]};
                min_cp = Min4Byte;
              end
            end else if (b[7:6] != 2'b10) begin
              bad = 1'b1;
            end else begin
              acc = {acc[14:0], b[5:0]};
              pending = pending - 2'd1;
              if (pending == 0) begin
                cp = acc;
                if (cp < {4'h0, min_cp} || cp > MaxCodePt ||
                    (cp >= SurrLo && cp <= SurrHi)) begin
                  bad = 1'b1;
                end else if (cp < SuppBase) begin
                  add_unit(fresh, cp[15:0]);
                end else begin
                  v = cp - SuppBase;
                  add_unit(fresh, HiSurrBase | {6'h0, v[19:10]});
                  add_unit(fresh, LoSurrBase | {6'h0, v[9:0]});
                end
                acc = '0;
                min_cp = '0;
              end
            end
          end
        end
        default: bad = 1'b1;
      endcase
      if (!bad && lst && (phase != EscNone || pending != 0)) bad = 1'b1;
      if (bad) begin
        fail.unit = '0;
        fail.eos = 1'b1;
        fail.err = 1'b1;
        decoded_units.push_back(fail);
        clear_escape();
        discarding = !lst;
        return 1'b1;
      end
      if (lst) begin
        if (fresh.size() > 0) fresh[fresh.size()-1].eos = 1'b1;
        clear_escape();
      end
      foreach (fresh[i]) decoded_units.push_back(fresh[i]);
      return 1'b1;
    endfunction

    function void check_result(logic [UnitW-1:0] unit, logic eos, logic err);
      dec_unit_t e;
      if (decoded_units.size() == 0) begin
        $error("unexpected result: out_unit %h end_of_string %b error %b", unit, eos, err);
        errors++;
        return;
      end
      e = decoded_units.pop_front();
      if (unit !== e.unit) begin
        $error("out_unit: expected %h, actual %h", e.unit, unit);
        errors++;
      end
      if (eos !== e.eos) begin
        $error("out_end_of_string: expected %b, actual %b", e.eos, eos);
        errors++;
      end
      if (err !== e.err) begin
        $error("out_error: expected %b, actual %b", e.err, err);
        errors++;
      end
    endfunction

    function int unsigned outstanding();
      return decoded_units.size();
    endfunction
  endclass

  logic             clk = 1'b0;
  logic             rst_n;
  logic             in_push;
  logic             in_full;
  logic [UnitW-1:0] in_code_unit;
  logic             in_last;
  logic             out_empty;
  logic             out_pop;
  logic [UnitW-1:0] out_unit;
  logic             out_end_of_string;
  logic             out_error;
  logic             cfg_valid;
  logic             cfg_ready;
  logic             cfg_data;

  decode_scoreboard_t sb = new();
  logic [UnitW-1:0] text_units[$];
  int unsigned      decoded_count;
  int unsigned      tx_idle_pct = 0;
  int unsigned      rx_idle_pct = 0;
  bit               hold_request = 1'b0;
  int unsigned      cycle_count = 0;

  uri_percent_utf8_decoder u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_push           (in_push),
    .in_full           (in_full),
    .in_code_unit      (in_code_unit),
    .in_last           (in_last),
    .out_empty         (out_empty),
    .out_pop           (out_pop),
    .out_unit          (out_unit),
    .out_end_of_string (out_end_of_string),
    .out_error         (out_error),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_data          (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Result side: random pops, with one long hold-off on request.
  initial begin
    out_pop = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        out_pop = 1'b0;
        repeat (HoldCycles) @(negedge clk);
        hold_request = 1'b0;
      end
      out_pop = ($urandom_range(99) >= rx_idle_pct);
      @(posedge clk);
      if (out_pop && !out_empty) sb.check_result(out_unit, out_end_of_string, out_error);
    end
  end

  function automatic logic [UnitW-1:0] hex_char(logic [3:0] n);
    if (n < 10) return 16'h0030 + 16'(n);
    if ($urandom_range(0, 1)) return 16'h0037 + 16'(n);
    return 16'h0057 + 16'(n);
  endfunction

  function automatic void add_escape(logic [7:0] b);
    text_units.push_back(PctChar);
    text_units.push_back(hex_char(b[7:4]));
    text_units.push_back(hex_char(b[3:0]));
  endfunction

  function automatic void add_code_point(logic [20:0] cp, int unsigned len);
    case (len)
      1: add_escape(cp[7:0]);
      2: begin
        add_escape({3'b110, cp[10:6]});
        add_escape({2'b10, cp[5:0]});
      end
      3: begin
        add_escape({4'b1110, cp[15:12]});
        add_escape({2'b10, cp[11:6]});
        add_escape({2'b10, cp[5:0]});
      end
      default: begin
        add_escape({5'b11110, cp[20:18]});
        add_escape({2'b10, cp[17:12]});
        add_escape({2'b10, cp[11:6]});
        add_escape({2'b10, cp[5:0]});
      end
    endcase
  endfunction

  function automatic logic [UnitW-1:0] plain_unit();
    logic [UnitW-1:0] u;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: u = 16'($urandom_range(16'h0020, 16'h007E));
      6, 7: u = 16'($urandom());
      8: u = $urandom_range(0, 1) ? 16'h0000 : 16'hFFFF;
      default: u = 16'($urandom_range(16'h0080, 16'hFFFF));
    endcase
    if (u == PctChar) u = 16'h0026;
    return u;
  endfunction

  function automatic logic [UnitW-1:0] non_hex_unit();
    if ($urandom_range(0, 1)) return 16'($urandom_range(16'h0067, 16'hFFFF));
    return 16'($urandom_range(16'h0000, 16'h002F));
  endfunction

  function automatic logic [7:0] reserved_byte();
    case ($urandom_range(0, 10))
      0: return 8'h23;
      1: return 8'h24;
      2: return 8'h26;
      3: return 8'h2B;
      4: return 8'h2C;
      5: return 8'h2F;
      6: return 8'h3A;
      7: return 8'h3B;
      8: return 8'h3D;
      9: return 8'h3F;
      default: return 8'h40;
    endcase
  endfunction

  function automatic void add_good_token();
    logic [20:0] cp;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: text_units.push_back(plain_unit());
      4: add_escape(reserved_byte());
      5: add_escape(8'($urandom_range(0, 8'h7F)));
      6: add_code_point(21'($urandom_range(21'h80, 21'h7FF)), 2);
      7: begin
        cp = 21'($urandom_range(21'h800, 21'hFFFF));
        if (cp >= SurrLo && cp <= SurrHi) cp = cp - 21'h1000;
        add_code_point(cp, 3);
      end
      8: add_code_point(21'($urandom_range(21'h10000, 21'h10FFFF)), 4);
      default: begin
        case ($urandom_range(0, 7))
          0: add_code_point(21'h80, 2);
          1: add_code_point(21'h7FF, 2);
          2: add_code_point(21'h800, 3);
          3: add_code_point(21'hD7FF, 3);
          4: add_code_point(21'hE000, 3);
          5: add_code_point(21'hFFFF, 3);
          6: add_code_point(21'h10000, 4);
          default: add_code_point(21'h10FFFF, 4);
        endcase
      end
    endcase
  endfunction

  function automatic void add_noise_token();
    case ($urandom_range(0, 5))
      0: add_escape(8'($urandom_range(0, 8'hFF)));
      1: begin
        text_units.push_back(PctChar);
        if ($urandom_range(0, 1)) text_units.push_back(hex_char(4'($urandom_range(0, 15))));
        text_units.push_back(non_hex_unit());
      end
      2: begin
        add_escape(8'($urandom_range(8'hC0, 8'hF7)));
        if ($urandom_range(0, 1)) text_units.push_back(plain_unit());
      end
      3: begin
        case ($urandom_range(0, 2))
          0: add_code_point(21'($urandom_range(0, 21'h7F)), 2);
          1: add_code_point(21'($urandom_range(0, 21'h7FF)), 3);
          default: add_code_point(21'($urandom_range(0, 21'hFFFF)), 4);
        endcase
      end
      4: begin
        if ($urandom_range(0, 1)) add_code_point(21'($urandom_range(SurrLo, SurrHi)), 3);
        else add_code_point(21'($urandom_range(21'h110000, 21'h1FFFFF)), 4);
      end
      default: begin
        text_units.push_back(PctChar);
        if ($urandom_range(0, 1)) text_units.push_back(hex_char(4'($urandom_range(0, 15))));
      end
    endcase
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic push_unit(input logic [UnitW-1:0] cu, input logic lst);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_push = 1'b0;
      @(negedge clk);
    end
    in_push = 1'b1;
    in_code_unit = cu;
    in_last = lst;
    @(posedge clk);
    while (in_full) @(posedge clk);
    void'(sb.note_request(cu, lst));
    decoded_count++;
    @(negedge clk);
  endtask

  task automatic send_text();
    for (int i = 0; i < text_units.size(); i++) begin
      push_unit(text_units[i], i == text_units.size() - 1);
    end
    text_units.delete();
  endtask

  task automatic write_mode(input logic value);
    in_push = 1'b0;
    while (sb.outstanding() != 0) @(negedge clk);
    repeat (SettleCycles) @(negedge clk);
    cfg_valid = 1'b1;
    cfg_data = value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.mode = value;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic run_random(input int unsigned target, input int unsigned idle_pct);
    int unsigned ntok;
    tx_idle_pct = idle_pct;
    rx_idle_pct = idle_pct;
    decoded_count = 0;
    while (decoded_count < target) begin
      ntok = $urandom_range(1, 6);
      repeat (ntok) begin
        if ($urandom_range(99) < 15) add_noise_token();
        else add_good_token();
      end
      send_text();
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_push = 1'b0;
    in_code_unit = '0;
    in_last = 1'b0;
    cfg_valid = 1'b0;
    cfg_data = 1'b0;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    write_mode(1'b0);
    text_units = '{16'h0000, 16'hFFFF};
    send_text();
    text_units = '{PctChar, 16'h0032, 16'h0066};
    send_text();
    add_code_point(21'h1F600, 4);
    send_text();
    add_code_point(21'h0, 2);
    send_text();
    text_units = '{PctChar, 16'h0067, 16'h0078};
    send_text();

    write_mode(1'b1);
    run_random(120, 8);
    write_mode(1'b0);
    hold_request = 1'b1;
    run_random(150, 0);
    write_mode(1'b1);
    run_random(100, 8);
    write_mode(1'b0);
    run_random(100, 8);

    in_push = 1'b0;
    while (sb.outstanding() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/urid_pkg.sv
design/urid_front.sv
design/urid_fifo.sv
design/urid_back.sv
design/uri_percent_utf8_decoder.sv
verif/tb_uri_percent_utf8_decoder.sv
